/* hdl/ivrc_pkg.sv */
`timescale 1ns / 1ps
// Shared widths, defaults and beat types for the indexed vertex reuse cache.
package ivrc_pkg;

  localparam int INDEX_W     = 32;
  localparam int SLOT_W      = 10;
  localparam int BATCH_LEN_W = 11;

  localparam logic [BATCH_LEN_W-1:0] BATCH_LEN_RESET = 11'd96;

  localparam int CACHE_ENTRIES_DEF = 32;
  localparam int BATCH_MAX_DEF     = 1024;

  typedef struct packed {
    logic [INDEX_W-1:0] vertex_index;
    logic               last_in_draw;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              was_miss;
    logic              batch_end;
  } out_item_t;

endpackage

/* hdl/ivrc_line_map.sv */
`timescale 1ns / 1ps
// Pipelined mapping of a vertex index to its direct-mapped cache line.
module ivrc_line_map #(
  parameter int CACHE_ENTRIES = ivrc_pkg::CACHE_ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             adv,
  input  logic                             in_valid_i,
  input  ivrc_pkg::in_item_t               in_item_i,
  output logic                             map_valid_o,
  output ivrc_pkg::in_item_t               map_item_o,
  output logic [$clog2(CACHE_ENTRIES)-1:0] map_line_o
);

  localparam int  LINE_W  = $clog2(CACHE_ENTRIES);
  localparam bit  IS_POW2 = (CACHE_ENTRIES & (CACHE_ENTRIES - 1)) == 0;

  if (IS_POW2) begin : g_mask
    // Low index bits select the line.
    logic                 v_r;
    ivrc_pkg::in_item_t   item_r;
    logic [LINE_W-1:0]    line_r;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (adv) begin
        v_r <= in_valid_i;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        item_r <= in_item_i;
        line_r <= in_item_i.vertex_index[LINE_W-1:0];
      end
    end

    assign map_valid_o = v_r;
    assign map_item_o  = item_r;
    assign map_line_o  = line_r;

  end else begin : g_mod
    // Fold the upper half: p = hi * (2^16 mod C) + lo keeps the residue, p < 2^27.
    // Then q = floor(p / C) by reciprocal multiply, and line = p - q * C.
    localparam int PROD_W = 27;
    localparam int SHIFT  = PROD_W + LINE_W;
    localparam int Q_W    = PROD_W + 1 - LINE_W;
    localparam int WIDE_W = 2 * PROD_W + 1;
    localparam logic [LINE_W-1:0] R16 = LINE_W'((64'd1 << 16) % CACHE_ENTRIES);
    localparam logic [PROD_W:0]   RECIP =
      (PROD_W + 1)'(((64'd1 << SHIFT) + 64'(CACHE_ENTRIES) - 64'd1) / 64'(CACHE_ENTRIES));

    logic                 v1_r, v2_r, v3_r;
    ivrc_pkg::in_item_t   it1_r, it2_r, it3_r;
    logic [PROD_W-1:0]    p1_r, p2_r;
    logic [Q_W-1:0]       q_r;
    logic [LINE_W-1:0]    line_r;
    logic [PROD_W-1:0]    p_nxt;
    logic [WIDE_W-1:0]    prod;
    logic [PROD_W-1:0]    qc;
    logic [PROD_W-1:0]    rem;

    assign p_nxt = PROD_W'(in_item_i.vertex_index[31:16]) * PROD_W'(R16)
                 + PROD_W'(in_item_i.vertex_index[15:0]);
    assign prod  = WIDE_W'(p1_r) * WIDE_W'(RECIP);
    assign qc    = PROD_W'(q_r) * PROD_W'(CACHE_ENTRIES);
    assign rem   = p2_r - qc;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v1_r <= 1'b0;
        v2_r <= 1'b0;
        v3_r <= 1'b0;
      end else if (adv) begin
        v1_r <= in_valid_i;
        v2_r <= v1_r;
        v3_r <= v2_r;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        it1_r  <= in_item_i;
        it2_r  <= it1_r;
        it3_r  <= it2_r;
        p1_r   <= p_nxt;
        p2_r   <= p1_r;
        q_r    <= prod[SHIFT +: Q_W];
        line_r <= rem[LINE_W-1:0];
      end
    end

    assign map_valid_o = v3_r;
    assign map_item_o  = it3_r;
    assign map_line_o  = line_r;
  end

endmodule

/* hdl/ivrc_lookup.sv */
`timescale 1ns / 1ps
// Tag/slot memory, valid bits, slot counter and batch counter: lookup and fill.
module ivrc_lookup #(
  parameter int CACHE_ENTRIES = ivrc_pkg::CACHE_ENTRIES_DEF,
  parameter int BATCH_MAX     = ivrc_pkg::BATCH_MAX_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  adv,
  input  logic [ivrc_pkg::BATCH_LEN_W-1:0]      batch_len_i,
  input  logic                                  map_valid_i,
  input  ivrc_pkg::in_item_t                    map_item_i,
  input  logic [$clog2(CACHE_ENTRIES)-1:0]      map_line_i,
  output logic                                  res_valid_o,
  output ivrc_pkg::out_item_t                   res_o
);

  localparam int LINE_W = $clog2(CACHE_ENTRIES);
  localparam int POS_W  = $clog2(BATCH_MAX);
  localparam int CMP_W  = (ivrc_pkg::BATCH_LEN_W > POS_W + 1) ?
                          ivrc_pkg::BATCH_LEN_W : POS_W + 1;

  typedef struct packed {
    logic [ivrc_pkg::INDEX_W-1:0] tag;
    logic [ivrc_pkg::SLOT_W-1:0]  slot;
  } entry_t;

  entry_t                       mem [CACHE_ENTRIES];
  entry_t                       rd_r;
  entry_t                       fwd_r;
  logic                         fwd_hit_r;

  logic                         b_valid_r;
  ivrc_pkg::in_item_t           b_item_r;
  logic [LINE_W-1:0]            b_line_r;

  logic [CACHE_ENTRIES-1:0]     valid_r;
  logic [ivrc_pkg::SLOT_W-1:0]  next_slot_r;
  logic [POS_W-1:0]             pos_r;

  entry_t                       cur;
  logic                         hit;
  logic                         step;
  logic [CMP_W-1:0]             size_ext;
  logic [CMP_W-1:0]             eff;
  logic [CMP_W-1:0]             pos_inc;
  logic                         done;

  assign cur  = fwd_hit_r ? fwd_r : rd_r;
  assign hit  = valid_r[b_line_r] && (cur.tag == b_item_r.vertex_index);
  assign step = adv && b_valid_r;

  assign size_ext = CMP_W'(batch_len_i);
  assign eff      = (size_ext == '0) ? CMP_W'(1) :
                    (size_ext > CMP_W'(BATCH_MAX)) ? CMP_W'(BATCH_MAX) : size_ext;
  assign pos_inc  = CMP_W'(pos_r) + CMP_W'(1);
  assign done     = b_item_r.last_in_draw || (pos_inc >= eff);

  // Memory: one write port (fill on miss), one registered read port.
  always_ff @(posedge clk) begin
    if (step && !hit) begin
      mem[b_line_r] <= '{tag: b_item_r.vertex_index, slot: next_slot_r};
    end
    if (adv) begin
      rd_r <= mem[map_line_i];
    end
  end

  // Forward a fill that lands in the same cycle as the read of that line.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (adv) begin
      fwd_hit_r <= step && !hit && (b_line_r == map_line_i);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fwd_r    <= '{tag: b_item_r.vertex_index, slot: next_slot_r};
      b_item_r <= map_item_i;
      b_line_r <= map_line_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      valid_r     <= '0;
      next_slot_r <= '0;
      pos_r       <= '0;
    end else if (adv) begin
      b_valid_r <= map_valid_i;
      if (b_valid_r) begin
        if (done) begin
          valid_r     <= '0;
          next_slot_r <= '0;
          pos_r       <= '0;
        end else begin
          pos_r <= pos_inc[POS_W-1:0];
          if (!hit) begin
            valid_r[b_line_r] <= 1'b1;
            next_slot_r       <= next_slot_r + 1'b1;
          end
        end
      end
    end
  end

  assign res_valid_o    = b_valid_r;
  assign res_o.slot      = hit ? cur.slot : next_slot_r;
  assign res_o.was_miss  = !hit;
  assign res_o.batch_end = done;

endmodule

/* hdl/indexed_vertex_reuse_cache_unit.sv */
`timescale 1ns / 1ps
// Top level of the indexed vertex reuse cache: line map, lookup, output skid.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  ivrc_pkg::in_item_t (vertex_index, last_in_draw)
//   out_     output     out_valid/out_stall  ivrc_pkg::out_item_t (slot, was_miss, batch_end)
//   cfg_     input      cfg_we               cfg_wdata = indices per batch (11 bits)
//
// Throughput is one beat per cycle while in_stall is low. A taken beat passes the line
// map, the lookup register and the output register before it shows on out_valid. When
// CACHE_ENTRIES is not a power of two, the line map has fold/reciprocal/remainder stages.
// rst_n is synchronous: it clears valid bits, slot and batch counters, and
// loads the batch length with 96. Tag and slot memory are not cleared.
// A stall on out_ holds the result register; the next result parks in the skid
// register, and in_stall rises only while the skid register is full.
module indexed_vertex_reuse_cache_unit #(
  parameter int CACHE_ENTRIES = ivrc_pkg::CACHE_ENTRIES_DEF,
  parameter int BATCH_MAX     = ivrc_pkg::BATCH_MAX_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  ivrc_pkg::in_item_t               in_item,
  output logic                             out_valid,
  input  logic                             out_stall,
  output ivrc_pkg::out_item_t              out_item,
  input  logic                             cfg_we,
  input  logic [ivrc_pkg::BATCH_LEN_W-1:0] cfg_wdata
);

  localparam int LINE_W = $clog2(CACHE_ENTRIES);

  logic [ivrc_pkg::BATCH_LEN_W-1:0] batch_len_r;
  logic                             out_valid_r;
  ivrc_pkg::out_item_t              out_item_r;
  logic                             skid_valid_r;
  ivrc_pkg::out_item_t              skid_item_r;

  // Whole pipeline advances together; it freezes only while the skid is full.
  logic                             adv;
  logic                             map_valid;
  ivrc_pkg::in_item_t               map_item;
  logic [LINE_W-1:0]                map_line;
  logic                             res_valid;
  ivrc_pkg::out_item_t              res;

  assign adv = !skid_valid_r;

  // Batch length register: to be written only while idle (the block does not enforce this), so no shadowing.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      batch_len_r <= ivrc_pkg::BATCH_LEN_RESET;
    end else if (cfg_we) begin
      batch_len_r <= cfg_wdata;
    end
  end

  ivrc_line_map #(
    .CACHE_ENTRIES (CACHE_ENTRIES)
  ) u_line_map (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .in_valid_i  (in_valid),
    .in_item_i   (in_item),
    .map_valid_o (map_valid),
    .map_item_o  (map_item),
    .map_line_o  (map_line)
  );

  ivrc_lookup #(
    .CACHE_ENTRIES (CACHE_ENTRIES),
    .BATCH_MAX     (BATCH_MAX)
  ) u_lookup (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .batch_len_i  (batch_len_r),
    .map_valid_i  (map_valid),
    .map_item_i   (map_item),
    .map_line_i   (map_line),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  // Output register plus skid. While the skid is empty the lookup result is
  // taken every cycle: into the output register if it is free or draining,
  // otherwise into the skid. A full skid refills the output register first.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!skid_valid_r) begin
      if (out_valid_r && out_stall) begin
        skid_valid_r <= res_valid;
      end else begin
        out_valid_r <= res_valid;
      end
    end else if (!out_stall) begin
      out_valid_r  <= 1'b1;
      skid_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_valid_r) begin
      if (out_valid_r && out_stall) begin
        skid_item_r <= res;
      end else begin
        out_item_r <= res;
      end
    end else if (!out_stall) begin
      out_item_r <= skid_item_r;
    end
  end

  assign in_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

/* hdl/ivrc_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the indexed vertex reuse cache, bound to the top level.
module ivrc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input ivrc_pkg::out_item_t out_item
);

  logic                        out_fire;
  logic                        open_r;
  logic [ivrc_pkg::SLOT_W-1:0] exp_slot_r;

  assign out_fire = out_valid && !out_stall;

  // Track batch start and the slot the next miss must receive.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r     <= 1'b1;
      exp_slot_r <= '0;
    end else if (out_fire) begin
      open_r <= out_item.batch_end;
      if (out_item.batch_end) begin
        exp_slot_r <= '0;
      end else if (out_item.was_miss) begin
        exp_slot_r <= out_item.slot + 1'b1;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled out beat changed");

  a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |=> !in_stall)
    else $error("in_stall held after output drained");

  a_batch_open: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && open_r |-> out_item.was_miss && (out_item.slot == '0))
    else $error("first beat of batch is not a miss in slot zero");

  a_slot_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && out_item.was_miss |-> out_item.slot == exp_slot_r)
    else $error("miss slots not consecutive");

endmodule

bind indexed_vertex_reuse_cache_unit ivrc_checker u_ivrc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
